>>> rtl/bap_pkg.sv
// ----------------------------------------------------------------------------
// bap_pkg
// Shared types and constants of the block-average pixelation unit.
// ----------------------------------------------------------------------------
package bap_pkg;

   // Default limits, handed to the top level's parameters.
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int DEF_MAX_TILE   = 64;

   // Fixed field widths.
   localparam int CFG_W     = 13;
   localparam int TCFG_W    = 7;
   localparam int PIXEL_W   = 32;
   localparam int CHAN_W    = 8;
   localparam int COORD_W   = 12;
   localparam int SIZE_W    = 7;
   localparam int SUM_W     = 20;
   localparam int CNT_W     = 17;
   localparam int QUO_W     = 8;
   localparam int DIV_W     = CNT_W + QUO_W - 1;
   localparam int CSR_IDX_W = 2;

   // Queue between the front and the back.
   localparam int Q_DEPTH = 4;
   localparam int LEVEL_W = $clog2(Q_DEPTH + 1);

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_SIZE    = 2'd2;

   // Register reset values.
   localparam logic [CFG_W-1:0]  RST_IMAGE_WIDTH  = 13'd4096;
   localparam logic [CFG_W-1:0]  RST_IMAGE_HEIGHT = 13'd4096;
   localparam logic [TCFG_W-1:0] RST_TILE_SIZE    = 7'd8;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   // One finished tile waiting for its averages.
   typedef struct packed {
      logic [SUM_W-1:0]   sum_r;
      logic [SUM_W-1:0]   sum_g;
      logic [SUM_W-1:0]   sum_b;
      logic [CNT_W-1:0]   count;
      logic [COORD_W-1:0] tile_x;
      logic [COORD_W-1:0] tile_y;
      logic [SIZE_W-1:0]  tile_w;
      logic [SIZE_W-1:0]  tile_h;
      logic               frame_done;
   } tile_job_type;

endpackage

>>> rtl/bap_queue.sv
// ----------------------------------------------------------------------------
// bap_queue
// Small first-in first-out queue of tile jobs with a show-ahead read side.
// ----------------------------------------------------------------------------
module bap_queue
   import bap_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = Q_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic [$clog2(DEPTH+1)-1:0] level
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0]           slot_ff [DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [$clog2(DEPTH+1)-1:0] level_ff, level_in;

   // Pointer and fill level updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Storage of the queued items.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign level    = level_ff;

endmodule

>>> rtl/bap_front.sv
// ----------------------------------------------------------------------------
// bap_front
// Walks the image position, accumulates the colour sums of each tile column
// and hands every finished tile to the queue.
// ----------------------------------------------------------------------------
module bap_front
   import bap_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_TILE   = DEF_MAX_TILE
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIXEL_W-1:0]   req_pixel,
   input  logic [LEVEL_W-1:0]   q_level,
   output logic                 push_valid,
   output tile_job_type         push_job
);
   localparam int XW    = $clog2(MAX_WIDTH + 1);
   localparam int YW    = $clog2(MAX_HEIGHT + 1);
   localparam int TW    = $clog2(MAX_TILE + 1);
   localparam int DEPTH = MAX_WIDTH / 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int MW    = 3 * SUM_W;

   // Configuration registers.
   logic [CFG_W-1:0]  image_width_ff, image_height_ff;
   logic [TCFG_W-1:0] tile_size_ff;

   // Position counters.
   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic [TW-1:0] cit_ff, cit_in;
   logic [TW-1:0] rit_ff, rit_in;
   logic [AW-1:0] tcol_ff, tcol_in;

   // Accumulate stage.
   logic              s2_v_ff;
   logic [AW-1:0]     s2_tc_ff;
   logic              s2_first_ff;
   logic [CHAN_W-1:0] s2_r_ff, s2_g_ff, s2_b_ff;
   logic              s2_emit_ff;
   logic [XW-1:0]     s2_tx_ff;
   logic [YW-1:0]     s2_ty_ff;
   logic [TW-1:0]     s2_tw_ff, s2_th_ff;
   logic              s2_done_ff;

   // Sums memory and write-to-read forwarding.
   logic [MW-1:0] sums_mem [DEPTH];
   logic [MW-1:0] rd_ff;
   logic          fw_v_ff;
   logic [AW-1:0] fw_addr_ff;
   logic [MW-1:0] fw_data_ff;

   logic [XW-1:0] w_eff;
   logic [YW-1:0] h_eff;
   logic [TW-1:0] t_eff;
   logic          dims_ok, tiles_on, last_col, last_row, cit_end, rit_end;
   logic          emit, accept, restart;
   logic [XW-1:0] tx;
   logic [YW-1:0] ty;
   logic [TW-1:0] tw, th;
   logic [MW-1:0] base, sums_new;

   // Settings clipped to the limits of this build.
   assign w_eff = (32'(image_width_ff) > 32'(MAX_WIDTH)) ? XW'(MAX_WIDTH)
                                                         : XW'(image_width_ff);
   assign h_eff = (32'(image_height_ff) > 32'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT)
                                                           : YW'(image_height_ff);
   assign t_eff = (32'(tile_size_ff) > 32'(MAX_TILE)) ? TW'(MAX_TILE)
                                                      : TW'(tile_size_ff);

   assign dims_ok  = (w_eff != '0) && (h_eff != '0);
   assign tiles_on = t_eff > TW'(1);
   assign last_col = col_ff >= w_eff - 1'b1;
   assign last_row = row_ff >= h_eff - 1'b1;
   assign cit_end  = cit_ff >= t_eff - 1'b1;
   assign rit_end  = rit_ff >= t_eff - 1'b1;
   assign emit     = tiles_on && (cit_end || last_col) && (rit_end || last_row);

   // Tile origin and clipped size.
   assign tx = col_ff - XW'(cit_ff);
   assign ty = row_ff - YW'(rit_ff);
   assign tw = (32'(w_eff - tx) > 32'(t_eff)) ? t_eff : TW'(w_eff - tx);
   assign th = (32'(h_eff - ty) > 32'(t_eff)) ? t_eff : TW'(h_eff - ty);

   // Room is kept for the item in the accumulate stage and for this one.
   assign req_ready = (int'(q_level) + int'(s2_v_ff)) < Q_DEPTH;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign restart   = csr_valid && ((csr_index == CSR_IMAGE_WIDTH) ||
                                    (csr_index == CSR_IMAGE_HEIGHT) ||
                                    (csr_index == CSR_TILE_SIZE));

   // Next position in raster order.
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      cit_in  = cit_ff;
      rit_in  = rit_ff;
      tcol_in = tcol_ff;
      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         cit_in  = '0;
         rit_in  = '0;
         tcol_in = '0;
      end else if (accept && dims_ok) begin
         if (last_col) begin
            col_in  = '0;
            cit_in  = '0;
            tcol_in = '0;
            if (last_row) begin
               row_in = '0;
               rit_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
               if (tiles_on) begin
                  rit_in = rit_end ? '0 : rit_ff + 1'b1;
               end
            end
         end else begin
            col_in = col_ff + 1'b1;
            if (tiles_on) begin
               if (cit_end) begin
                  cit_in  = '0;
                  tcol_in = tcol_ff + 1'b1;
               end else begin
                  cit_in = cit_ff + 1'b1;
               end
            end
         end
      end
   end

   // Configuration and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= RST_IMAGE_WIDTH;
         image_height_ff <= RST_IMAGE_HEIGHT;
         tile_size_ff    <= RST_TILE_SIZE;
         col_ff          <= '0;
         row_ff          <= '0;
         cit_ff          <= '0;
         rit_ff          <= '0;
         tcol_ff         <= '0;
         s2_v_ff         <= 1'b0;
         fw_v_ff         <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
               CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
               CSR_TILE_SIZE:    tile_size_ff    <= csr_wdata[TCFG_W-1:0];
               default: ;
            endcase
         end
         col_ff  <= col_in;
         row_ff  <= row_in;
         cit_ff  <= cit_in;
         rit_ff  <= rit_in;
         tcol_ff <= tcol_in;
         s2_v_ff <= accept && dims_ok && tiles_on;
         fw_v_ff <= s2_v_ff;
      end
   end

   // Payload of the accumulate stage.
   always_ff @(posedge clock) begin
      s2_tc_ff    <= tcol_ff;
      s2_first_ff <= (cit_ff == '0) && (rit_ff == '0);
      s2_r_ff     <= req_pixel[7:0];
      s2_g_ff     <= req_pixel[15:8];
      s2_b_ff     <= req_pixel[23:16];
      s2_emit_ff  <= emit;
      s2_tx_ff    <= tx;
      s2_ty_ff    <= ty;
      s2_tw_ff    <= tw;
      s2_th_ff    <= th;
      s2_done_ff  <= last_col && last_row;
      fw_addr_ff  <= s2_tc_ff;
      fw_data_ff  <= sums_new;
   end

   // The read misses only the write made in the same cycle; that one is forwarded.
   assign base = (fw_v_ff && (fw_addr_ff == s2_tc_ff)) ? fw_data_ff : rd_ff;

   // New sums: the first pixel of a tile starts them afresh.
   always_comb begin
      if (s2_first_ff) begin
         sums_new = {SUM_W'(s2_r_ff), SUM_W'(s2_g_ff), SUM_W'(s2_b_ff)};
      end else begin
         sums_new = {base[3*SUM_W-1:2*SUM_W] + SUM_W'(s2_r_ff),
                     base[2*SUM_W-1:SUM_W]   + SUM_W'(s2_g_ff),
                     base[SUM_W-1:0]         + SUM_W'(s2_b_ff)};
      end
   end

   // Sums memory: read at the current tile column, written by the accumulate stage.
   always_ff @(posedge clock) begin
      rd_ff <= sums_mem[tcol_ff];
      if (s2_v_ff) begin
         sums_mem[s2_tc_ff] <= sums_new;
      end
   end

   // Finished tile for the back end.
   assign push_valid          = s2_v_ff && s2_emit_ff;
   assign push_job.sum_r      = sums_new[3*SUM_W-1:2*SUM_W];
   assign push_job.sum_g      = sums_new[2*SUM_W-1:SUM_W];
   assign push_job.sum_b      = sums_new[SUM_W-1:0];
   assign push_job.count      = CNT_W'(32'(s2_tw_ff) * 32'(s2_th_ff));
   assign push_job.tile_x     = COORD_W'(s2_tx_ff);
   assign push_job.tile_y     = COORD_W'(s2_ty_ff);
   assign push_job.tile_w     = SIZE_W'(s2_tw_ff);
   assign push_job.tile_h     = SIZE_W'(s2_th_ff);
   assign push_job.frame_done = s2_done_ff;

endmodule

>>> rtl/bap_back.sv
// ----------------------------------------------------------------------------
// bap_back
// Divides the three colour sums of a tile by its pixel count, one quotient
// bit a cycle, and holds the result item until it is taken.
// ----------------------------------------------------------------------------
module bap_back
   import bap_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                job_ready,
   input  tile_job_type        job,
   output logic                job_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PIXEL_W-1:0]  rsp_tile_color,
   output logic [COORD_W-1:0]  rsp_tile_x,
   output logic [COORD_W-1:0]  rsp_tile_y,
   output logic [SIZE_W-1:0]   rsp_tile_w,
   output logic [SIZE_W-1:0]   rsp_tile_h,
   output logic                rsp_frame_done
);
   localparam int STEP_W = $clog2(QUO_W);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_SEND = 3'b100
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  rem_r_ff, rem_g_ff, rem_b_ff;
   logic [SUM_W-1:0]  rem_r_in, rem_g_in, rem_b_in;
   logic [QUO_W-1:0]  q_r_ff, q_g_ff, q_b_ff;
   logic [QUO_W-1:0]  q_r_in, q_g_in, q_b_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [COORD_W-1:0] x_ff, y_ff;
   logic [SIZE_W-1:0]  w_ff, h_ff;
   logic               done_ff;
   logic               ge_r, ge_g, ge_b;

   // The quotient fits in eight bits, so the divisor starts shifted by seven.
   assign ge_r = DIV_W'(rem_r_ff) >= div_ff;
   assign ge_g = DIV_W'(rem_g_ff) >= div_ff;
   assign ge_b = DIV_W'(rem_b_ff) >= div_ff;

   assign job_pop = (state_ff == ST_IDLE) && job_ready;

   // Sequencer and divider step.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rem_r_in = rem_r_ff;
      rem_g_in = rem_g_ff;
      rem_b_in = rem_b_ff;
      q_r_in   = q_r_ff;
      q_g_in   = q_g_ff;
      q_b_in   = q_b_ff;
      div_in   = div_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_ready) begin
               rem_r_in = job.sum_r;
               rem_g_in = job.sum_g;
               rem_b_in = job.sum_b;
               div_in   = DIV_W'(job.count) << (QUO_W - 1);
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (ge_r) rem_r_in = rem_r_ff - SUM_W'(div_ff);
            if (ge_g) rem_g_in = rem_g_ff - SUM_W'(div_ff);
            if (ge_b) rem_b_in = rem_b_ff - SUM_W'(div_ff);
            q_r_in  = {q_r_ff[QUO_W-2:0], ge_r};
            q_g_in  = {q_g_ff[QUO_W-2:0], ge_g};
            q_b_in  = {q_b_ff[QUO_W-2:0], ge_b};
            div_in  = div_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(QUO_W - 1)) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      rem_r_ff <= rem_r_in;
      rem_g_ff <= rem_g_in;
      rem_b_ff <= rem_b_in;
      q_r_ff   <= q_r_in;
      q_g_ff   <= q_g_in;
      q_b_ff   <= q_b_in;
      div_ff   <= div_in;
      if (job_pop) begin
         x_ff    <= job.tile_x;
         y_ff    <= job.tile_y;
         w_ff    <= job.tile_w;
         h_ff    <= job.tile_h;
         done_ff <= job.frame_done;
      end
   end

   assign rsp_valid      = state_ff == ST_SEND;
   assign rsp_tile_color = {ALPHA_OPAQUE, q_b_ff, q_g_ff, q_r_ff};
   assign rsp_tile_x     = x_ff;
   assign rsp_tile_y     = y_ff;
   assign rsp_tile_w     = w_ff;
   assign rsp_tile_h     = h_ff;
   assign rsp_frame_done = done_ff;

endmodule

>>> rtl/block_average_pixelate_unit.sv
// ----------------------------------------------------------------------------
// block_average_pixelate_unit
// Mosaic pixelation: one averaged colour item per finished tile.
// ----------------------------------------------------------------------------
// Pixels enter in raster order at up to one item per clock; the front end
// adds each pixel into its tile column's sums through a two-stage
// read-modify-write of the sums memory with forwarding. Each finished tile
// is queued (four entries) for the back end, whose shared divider produces
// one quotient bit per cycle for all three colours; there a tile item goes
// through a load, eight divide steps and the output state. With small
// tiles the divider sets the sustained rate and the queue then holds the
// input back. Configuration writes restart the frame.
module block_average_pixelate_unit
   import bap_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_TILE   = DEF_MAX_TILE
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIXEL_W-1:0]   req_pixel,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PIXEL_W-1:0]   rsp_tile_color,
   output logic [COORD_W-1:0]   rsp_tile_x,
   output logic [COORD_W-1:0]   rsp_tile_y,
   output logic [SIZE_W-1:0]    rsp_tile_w,
   output logic [SIZE_W-1:0]    rsp_tile_h,
   output logic                 rsp_frame_done
);
   logic               push_valid, job_pop;
   tile_job_type       push_job, pop_job;
   logic [LEVEL_W-1:0] q_level;

   // Front end: position tracking and accumulation.
   bap_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_TILE   (MAX_TILE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_pixel  (req_pixel),
      .q_level    (q_level),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   // Queue of finished tiles.
   bap_queue #(
      .WIDTH (($bits(tile_job_type))),
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_job),
      .pop       (job_pop),
      .pop_data  (pop_job),
      .level     (q_level)
   );

   // Back end: averaging and result item.
   bap_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_ready      (q_level != '0),
      .job            (pop_job),
      .job_pop        (job_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tile_color (rsp_tile_color),
      .rsp_tile_x     (rsp_tile_x),
      .rsp_tile_y     (rsp_tile_y),
      .rsp_tile_w     (rsp_tile_w),
      .rsp_tile_h     (rsp_tile_h),
      .rsp_frame_done (rsp_frame_done)
   );

   // The front end never pushes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (int'(q_level) < Q_DEPTH))
      else $error("tile queue overflow");

   // The back end never takes from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (q_level != '0))
      else $error("tile queue underflow");

   // A result always describes a tile with pixels and an opaque colour.
   a_result_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_tile_w != '0) && (rsp_tile_h != '0) &&
                     (rsp_tile_color[31:24] == ALPHA_OPAQUE)))
      else $error("malformed tile item");

endmodule
